// ===== rtl/bpfa_pkg.sv =====
// shared types and constants of the bitmap page frame allocator
package bpfa_pkg;

	localparam int CMD_W   = 3;
	localparam int START_W = 12;
	localparam int COUNT_W = 13;
	localparam int FOUND_W = 12;
	localparam int FREE_W  = 13;
	localparam int CNT_W   = 16;
	localparam int TOTAL_W = 13;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
	localparam logic [FREE_W-1:0]  FREE_MAX    = 13'h1FFF;
	localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC_ONE = 3'd0,
		CMD_ALLOC_RUN = 3'd1,
		CMD_FREE      = 3'd2,
		CMD_LOCK      = 3'd3,
		CMD_UNRESERVE = 3'd4,
		CMD_RESERVE   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ONE_RD,
		ST_ONE_CHK,
		ST_RUN_RD,
		ST_RUN_CHK,
		ST_RANGE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               ok;
		logic [FOUND_W-1:0] found_page;
		logic [FREE_W-1:0]  free_pages;
		logic [CNT_W-1:0]   used_pages;
		logic [CNT_W-1:0]   reserved_pages;
	} res_t;

endpackage

// ===== rtl/bpfa_req_if.sv =====
// command channel interface
interface bpfa_req_if;
	logic                         valid;
	logic                         ready;
	logic [bpfa_pkg::CMD_W-1:0]   cmd;
	logic [bpfa_pkg::START_W-1:0] start_page;
	logic [bpfa_pkg::COUNT_W-1:0] page_count;

	modport source (output valid, cmd, start_page, page_count, input ready);
	modport sink (input valid, cmd, start_page, page_count, output ready);
endinterface

// ===== rtl/bpfa_rsp_if.sv =====
// result channel interface
interface bpfa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [bpfa_pkg::FOUND_W-1:0] found_page;
	logic [bpfa_pkg::FREE_W-1:0]  free_pages;
	logic [bpfa_pkg::CNT_W-1:0]   used_pages;
	logic [bpfa_pkg::CNT_W-1:0]   reserved_pages;

	modport source (output valid, ok, found_page, free_pages, used_pages, reserved_pages,
		input ready);
	modport sink (input valid, ok, found_page, free_pages, used_pages, reserved_pages,
		output ready);
endinterface

// ===== rtl/bpfa_map_ram.sv =====
// one bit per page frame, synchronous read
module bpfa_map_ram #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);
	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/bpfa_engine.sv =====
// command sequencer: search, range walk, counters and hint
module bpfa_engine #(
	parameter int MAX_PAGES = 4096,
	parameter int AW = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bpfa_pkg::CMD_W-1:0]   cmd,
	input  logic [bpfa_pkg::START_W-1:0] start_page,
	input  logic [bpfa_pkg::COUNT_W-1:0] page_count,
	input  logic [bpfa_pkg::TOTAL_W-1:0] total_pages,
	input  logic                         slot_free,
	output logic                         idle,
	output logic                         done,
	output bpfa_pkg::res_t               res,
	output logic                         we,
	output logic [AW-1:0]                waddr,
	output logic                         wdata,
	output logic [AW-1:0]                raddr,
	input  logic                         rdata
);
	import bpfa_pkg::*;

	localparam int CW = (((AW + 1) > 13) ? (AW + 1) : 13) + 1;
	localparam int FW = (CW > 17) ? CW : 17;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_PAGES);

	state_t state_q, state_d;
	logic [CW-1:0] hint_q, hint_d, s_q, s_d, p_q, p_d, i_q, i_d, end_q, end_d;
	logic [COUNT_W-1:0] len_q, len_d;
	logic [CMD_W-1:0] cmd_q, cmd_d;
	logic ok_q, ok_d;
	logic [FOUND_W-1:0] found_q, found_d;
	logic [CNT_W-1:0] used_q, used_d, rsv_q, rsv_d;

	logic [CW-1:0] lim, tot_c, sum_c, run_end;
	logic [FW-1:0] lim_f, taken_f, freep_f;
	logic is_range, sets, lowers;

	assign tot_c   = CW'(total_pages);
	assign lim     = (tot_c < MAX_C) ? tot_c : MAX_C;
	assign sum_c   = CW'(start_page) + CW'(page_count);
	assign run_end = s_q + CW'(len_q);
	assign is_range = (cmd == CMD_FREE) || (cmd == CMD_LOCK) || (cmd == CMD_UNRESERVE)
		|| (cmd == CMD_RESERVE);
	assign sets   = (cmd_q == CMD_LOCK) || (cmd_q == CMD_RESERVE) || (cmd_q == CMD_ALLOC_RUN);
	assign lowers = (cmd_q == CMD_FREE) || (cmd_q == CMD_UNRESERVE);

	assign lim_f   = FW'(lim);
	assign taken_f = FW'(used_q) + FW'(rsv_q);
	assign freep_f = (lim_f > taken_f) ? (lim_f - taken_f) : '0;

	always_comb begin
		res.ok             = ok_q;
		res.found_page     = found_q;
		res.free_pages     = (freep_f > FW'(FREE_MAX)) ? FREE_MAX : freep_f[FREE_W-1:0];
		res.used_pages     = used_q;
		res.reserved_pages = rsv_q;
	end

	assign idle = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			hint_q  <= '0;
			used_q  <= '0;
			rsv_q   <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			hint_q  <= hint_d;
			used_q  <= used_d;
			rsv_q   <= rsv_d;
			i_q     <= i_d;
		end
	end

	always_ff @(posedge clk) begin
		s_q     <= s_d;
		p_q     <= p_d;
		end_q   <= end_d;
		len_q   <= len_d;
		cmd_q   <= cmd_d;
		ok_q    <= ok_d;
		found_q <= found_d;
	end

	always_comb begin
		state_d = state_q;
		hint_d  = hint_q;
		s_d     = s_q;
		p_d     = p_q;
		i_d     = i_q;
		end_d   = end_q;
		len_d   = len_q;
		cmd_d   = cmd_q;
		ok_d    = ok_q;
		found_d = found_q;
		used_d  = used_q;
		rsv_d   = rsv_q;
		we      = 1'b0;
		waddr   = i_q[AW-1:0];
		wdata   = 1'b0;
		raddr   = (state_q == ST_ONE_RD) ? hint_q[AW-1:0] : p_q[AW-1:0];
		done    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we  = 1'b1;
				i_d = i_q + 1'b1;
				if (i_q == MAX_C - 1'b1) begin
					i_d     = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd_d   = cmd;
					ok_d    = is_range;
					found_d = '0;
					i_d     = CW'(start_page);
					end_d   = (sum_c < lim) ? sum_c : lim;
					s_d     = hint_q;
					p_d     = hint_q;
					len_d   = page_count;
					case (cmd)
						CMD_ALLOC_ONE: state_d = ST_ONE_RD;
						CMD_ALLOC_RUN: state_d = ST_RUN_RD;
						CMD_FREE, CMD_LOCK, CMD_UNRESERVE, CMD_RESERVE: state_d = ST_RANGE;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_ONE_RD: begin
				state_d = (hint_q >= lim) ? ST_DONE : ST_ONE_CHK;
			end
			ST_ONE_CHK: begin
				hint_d = hint_q + 1'b1;
				if (!rdata) begin
					we      = 1'b1;
					waddr   = hint_q[AW-1:0];
					wdata   = 1'b1;
					used_d  = (used_q != CNT_MAX) ? used_q + 1'b1 : CNT_MAX;
					found_d = hint_q[FOUND_W-1:0];
					ok_d    = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_ONE_RD;
				end
			end
			ST_RUN_RD: begin
				if (s_q >= lim) begin
					hint_d  = s_q;
					state_d = ST_DONE;
				end else if (p_q == run_end) begin
					hint_d  = run_end;
					found_d = s_q[FOUND_W-1:0];
					ok_d    = 1'b1;
					i_d     = s_q;
					end_d   = run_end;
					state_d = ST_RANGE;
				end else if (p_q >= lim) begin
					s_d = p_q + 1'b1;
					p_d = p_q + 1'b1;
				end else begin
					state_d = ST_RUN_CHK;
				end
			end
			ST_RUN_CHK: begin
				p_d = p_q + 1'b1;
				if (rdata) begin
					s_d = p_q + 1'b1;
				end
				state_d = ST_RUN_RD;
			end
			ST_RANGE: begin
				if (i_q < end_q) begin
					we    = 1'b1;
					wdata = sets;
					i_d   = i_q + 1'b1;
					case (cmd_q)
						CMD_LOCK, CMD_ALLOC_RUN: begin
							used_d = (used_q != CNT_MAX) ? used_q + 1'b1 : CNT_MAX;
						end
						CMD_RESERVE: begin
							rsv_d = (rsv_q != CNT_MAX) ? rsv_q + 1'b1 : CNT_MAX;
						end
						CMD_FREE: begin
							used_d = (used_q != '0) ? used_q - 1'b1 : used_q;
						end
						CMD_UNRESERVE: begin
							rsv_d = (rsv_q != '0) ? rsv_q - 1'b1 : rsv_q;
						end
						default: ;
					endcase
					if (lowers && (hint_q > i_q)) begin
						hint_d = i_q;
					end
				end else begin
					i_d     = '0;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/bitmap_page_frame_allocator_unit.sv =====
// top level of the bitmap page frame allocator
//  channel   dir  signals                                                  role
//  req       in   valid ready cmd start_page page_count                   command transfer
//  rsp       out  valid ready ok found_page free_pages used_pages          result transfer
//                 reserved_pages
//  cfg       in   cfg_we cfg_wdata                                         total_pages write
// range commands walk the range one page at a time; allocate one reads and checks
// frames from the hint until it finds a free one, allocate run probes frames for a free run,
// then locks its pages; the frame map has one bit read or written per cycle
// after reset a clearing pass writes zero to all MAX_PAGES frames of the map; req.ready stays low
// a result waits in the output register while the next command is taken
module bitmap_page_frame_allocator_unit #(
	parameter int MAX_PAGES = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bpfa_req_if.sink                     req,
	bpfa_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [bpfa_pkg::TOTAL_W-1:0] cfg_wdata
);
	import bpfa_pkg::*;

	localparam int AW = $clog2(MAX_PAGES);

	logic [TOTAL_W-1:0] total_q;
	logic out_valid_q;
	res_t out_q, res;
	logic idle, done, slot_free, start;
	logic we, wdata, rdata;
	logic [AW-1:0] waddr, raddr;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = idle;
	assign start     = req.valid && idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= TOTAL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.ok             = out_q.ok;
	assign rsp.found_page     = out_q.found_page;
	assign rsp.free_pages     = out_q.free_pages;
	assign rsp.used_pages     = out_q.used_pages;
	assign rsp.reserved_pages = out_q.reserved_pages;

	bpfa_engine #(.MAX_PAGES(MAX_PAGES), .AW(AW)) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (req.cmd),
		.start_page  (req.start_page),
		.page_count  (req.page_count),
		.total_pages (total_q),
		.slot_free   (slot_free),
		.idle        (idle),
		.done        (done),
		.res         (res),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.raddr       (raddr),
		.rdata       (rdata)
	);

	bpfa_map_ram #(.DEPTH(MAX_PAGES), .AW(AW)) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);
endmodule
